FILE: src/lfc_pkg.sv
// ----------------------------------------------------------------------------
// lfc_pkg
// shared types, constants and helper functions of the tracking controller
// ----------------------------------------------------------------------------
package lfc_pkg;

  localparam int CORDIC_STEPS_DEF = 16;

  // robot selector codes
  localparam logic [1:0] SEL_LEADER   = 2'd0;
  localparam logic [1:0] SEL_FOLLOWER = 2'd1;
  localparam logic [1:0] SEL_OTHER    = 2'd2;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_GOAL_X  = 2'd0,
    CFG_GOAL_Y  = 2'd1,
    CFG_GAIN    = 2'd2,
    CFG_SPEED_W = 2'd3
  } cfg_idx_e;

  // configuration reset values
  localparam logic signed [31:0] GOAL_X_RST  = 32'sd46359;
  localparam logic signed [31:0] GOAL_Y_RST  = 32'sd46323;
  localparam logic [7:0]         GAIN_RST    = 8'd5;
  localparam logic [14:0]        SPEED_W_RST = 15'd4096;

  // angles scaled by 2^30
  localparam logic signed [34:0] ANG_PI     = 35'sd3373259426;
  localparam logic signed [34:0] ANG_HALFPI = 35'sd1686629713;
  localparam logic signed [34:0] ANG_TWOPI  = 35'sd6746518852;
  localparam logic signed [33:0] CORDIC_K   = 34'sd652032874;

  // product term clamp
  localparam logic [40:0] TERM_LIM = 41'h100_0000_0000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_CS1,
    S_CS2,
    S_SQW,
    S_MSEL,
    S_MLO,
    S_MHI,
    S_MACC,
    S_DONE
  } ctrl_state_e;

  // product sequence of the shared multiplier
  typedef enum logic [2:0] {
    P_CDX = 3'd0,
    P_SDY = 3'd1,
    P_CDY = 3'd2,
    P_SDX = 3'd3,
    P_VCE = 3'd4,
    P_KE1 = 3'd5,
    P_KE2 = 3'd6,
    P_KE3 = 3'd7
  } prod_e;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_SQR,
    SQ_SUM,
    SQ_ITER
  } sq_phase_e;

  typedef struct packed {
    logic  load;
    logic  prep;
    logic  cordic_start;
    logic  ang_sel_e3;
    logic  latch_cs;
    logic  latch_ce3;
    logic  sqrt_start;
    logic  gain_load;
    logic  mul_sel;
    logic  mul_lo;
    logic  mul_hi;
    logic  mul_acc;
    logic  out_load;
    prod_e prod;
  } dp_cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [30:0] atan_lut(input logic [4:0] idx);
    logic [30:0] r;
    case (idx)
      5'd0:    r = 31'd843314856;
      5'd1:    r = 31'd497837829;
      5'd2:    r = 31'd263043836;
      5'd3:    r = 31'd133525158;
      5'd4:    r = 31'd67021686;
      5'd5:    r = 31'd33543515;
      5'd6:    r = 31'd16775850;
      5'd7:    r = 31'd8388437;
      5'd8:    r = 31'd4194282;
      5'd9:    r = 31'd2097149;
      5'd10:   r = 31'd1048575;
      5'd11:   r = 31'd524287;
      5'd12:   r = 31'd262143;
      5'd13:   r = 31'd131071;
      5'd14:   r = 31'd65535;
      5'd15:   r = 31'd32767;
      5'd16:   r = 31'd16383;
      5'd17:   r = 31'd8191;
      5'd18:   r = 31'd4095;
      5'd19:   r = 31'd2047;
      5'd20:   r = 31'd1023;
      5'd21:   r = 31'd511;
      5'd22:   r = 31'd255;
      5'd23:   r = 31'd127;
      default: r = 31'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [43:0] v);
    logic [31:0] r;
    if (v > 44'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -44'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: src/lfc_if.sv
// ----------------------------------------------------------------------------
// lfc_if
// handshake channels of the tracking controller: pose in, command out, config
// ----------------------------------------------------------------------------
interface lfc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        robot_select;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [15:0] heading;
  logic signed [15:0] linear_speed;
  logic signed [15:0] turn_rate;
  modport source (output valid, robot_select, pos_x, pos_y, heading, linear_speed,
                  turn_rate, input ready);
  modport sink (input valid, robot_select, pos_x, pos_y, heading, linear_speed,
                turn_rate, output ready);
endinterface

interface lfc_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] linear_command;
  logic signed [31:0] angular_command;
  modport source (output valid, linear_command, angular_command, input ready);
  modport sink (input valid, linear_command, angular_command, output ready);
endinterface

interface lfc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: src/lfc_cordic.sv
// ----------------------------------------------------------------------------
// lfc_cordic
// iterative rotation cordic, one micro-rotation per cycle, q1.15 outputs
// ----------------------------------------------------------------------------
module lfc_cordic #(
  parameter int CORDIC_STEPS = lfc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [16:0] angle_i,
  output logic               done_o,
  output logic signed [17:0] cos_o,
  output logic signed [17:0] sin_o
);

  localparam int CntW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [33:0]     x_q, x_d, y_q, y_d;
  logic signed [34:0]     z_q, z_d;
  logic                   flip_q, flip_d;
  logic signed [34:0]     z_pre;
  logic                   flip_pre;
  logic signed [33:0]     x_sh, y_sh, x_fin, y_fin;
  logic signed [34:0]     at;

  // range reduction into plus or minus half pi
  always_comb begin
    z_pre    = {{18{angle_i[16]}}, angle_i} <<< 17;
    flip_pre = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (z_pre > lfc_pkg::ANG_PI) begin
        z_pre = z_pre - lfc_pkg::ANG_TWOPI;
      end else if (z_pre < -lfc_pkg::ANG_PI) begin
        z_pre = z_pre + lfc_pkg::ANG_TWOPI;
      end
    end
    if (z_pre > lfc_pkg::ANG_HALFPI) begin
      z_pre    = z_pre - lfc_pkg::ANG_PI;
      flip_pre = 1'b1;
    end else if (z_pre < -lfc_pkg::ANG_HALFPI) begin
      z_pre    = z_pre + lfc_pkg::ANG_PI;
      flip_pre = 1'b1;
    end
  end

  always_comb begin
    x_sh   = x_q >>> cnt_q;
    y_sh   = y_q >>> cnt_q;
    at     = $signed({4'b0, lfc_pkg::atan_lut(5'(cnt_q))});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      x_d    = lfc_pkg::CORDIC_K;
      y_d    = '0;
      z_d    = z_pre;
      flip_d = flip_pre;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - y_sh;
        y_d = y_q + x_sh;
        z_d = z_q - at;
      end else begin
        x_d = x_q + y_sh;
        y_d = y_q - x_sh;
        z_d = z_q + at;
      end
      if (cnt_q == CntW'(CORDIC_STEPS - 1)) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  // round half up to q1.15
  always_comb begin
    x_fin = (flip_q ? -x_q : x_q) + 34'sd16384;
    y_fin = (flip_q ? -y_q : y_q) + 34'sd16384;
  end

  assign cos_o  = 18'(x_fin >>> 15);
  assign sin_o  = 18'(y_fin >>> 15);
  assign done_o = !busy_q;

endmodule

FILE: src/lfc_sqrt.sv
// ----------------------------------------------------------------------------
// lfc_sqrt
// natural frequency: floor sqrt of w^2*2^12 + weight*v^2, one bit per cycle
// ----------------------------------------------------------------------------
module lfc_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] turn_i,
  input  logic signed [15:0] speed_i,
  input  logic [14:0]        weight_i,
  output logic               done_o,
  output logic [22:0]        root_o
);

  lfc_pkg::sq_phase_e phase_q, phase_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [30:0]        ww_q, ww_d, vv_q, vv_d;
  logic [45:0]        n_q, n_d;
  logic [24:0]        rem_q, rem_d;
  logic [22:0]        root_q, root_d;
  logic signed [31:0] wsq, vsq;
  logic [26:0]        r2, trial;

  always_comb begin
    wsq     = turn_i * turn_i;
    vsq     = speed_i * speed_i;
    r2      = {rem_q, n_q[45:44]};
    trial   = {2'b00, root_q, 2'b01};
    phase_d = phase_q;
    cnt_d   = cnt_q;
    ww_d    = ww_q;
    vv_d    = vv_q;
    n_d     = n_q;
    rem_d   = rem_q;
    root_d  = root_q;
    case (phase_q)
      lfc_pkg::SQ_IDLE: begin
        if (start_i) begin
          phase_d = lfc_pkg::SQ_SQR;
        end
      end
      lfc_pkg::SQ_SQR: begin
        ww_d    = wsq[30:0];
        vv_d    = vsq[30:0];
        phase_d = lfc_pkg::SQ_SUM;
      end
      lfc_pkg::SQ_SUM: begin
        n_d     = {ww_q, 12'b0} + (46'(weight_i) * 46'(vv_q));
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        phase_d = lfc_pkg::SQ_ITER;
      end
      lfc_pkg::SQ_ITER: begin
        n_d = {n_q[43:0], 2'b00};
        if (r2 >= trial) begin
          rem_d  = 25'(r2 - trial);
          root_d = {root_q[21:0], 1'b1};
        end else begin
          rem_d  = r2[24:0];
          root_d = {root_q[21:0], 1'b0};
        end
        if (cnt_q == 5'd22) begin
          phase_d = lfc_pkg::SQ_IDLE;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      default: phase_d = lfc_pkg::SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= lfc_pkg::SQ_IDLE;
      cnt_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ww_q   <= ww_d;
    vv_q   <= vv_d;
    n_q    <= n_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = (phase_q == lfc_pkg::SQ_IDLE);
  assign root_o = root_q;

endmodule

FILE: src/lfc_datapath.sv
// ----------------------------------------------------------------------------
// lfc_datapath
// pose state, config registers, shared multiplier, accumulators, output word
// ----------------------------------------------------------------------------
module lfc_datapath #(
  parameter int CORDIC_STEPS = lfc_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfc_pkg::dp_cmd_t   cmd_i,
  output lfc_pkg::dp_stat_t  stat_o,
  input  logic [1:0]         robot_select_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] linear_speed_i,
  input  logic signed [15:0] turn_rate_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [31:0]        linear_command_o,
  output logic [31:0]        angular_command_o
);

  // config
  logic signed [31:0] goal_x_q, goal_y_q;
  logic [7:0]         gain_q;
  logic [14:0]        speed_w_q;

  // pose state
  logic signed [31:0] lx_q, ly_q, fx_q, fy_q;
  logic signed [15:0] lh_q, lv_q, lw_q, fh_q;

  // per-word working values
  logic signed [33:0] dx_q, dy_q;
  logic signed [17:0] c_q, s_q, ce3_q;
  logic signed [16:0] e3;
  logic [30:0]        k12_q, k3_q;
  logic signed [37:0] e1_q, e2_q;
  logic signed [53:0] acc_e_q;
  logic signed [43:0] lin_q, ang_q;

  // multiplier
  logic [37:0]        mag_a_q;
  logic [30:0]        mag_b_q;
  logic               neg_q, zero_q;
  logic [68:0]        prod_q;
  logic signed [37:0] op_a;
  logic signed [31:0] op_b;
  logic               op_neg, op_zero;
  logic [18:0]        chunk;
  logic [49:0]        pp;

  // accumulate path
  logic signed [69:0] sp;
  logic signed [53:0] esum, eround;
  logic [4:0]         sh;
  logic [68:0]        shr;
  logic [68:0]        rnd;
  logic [40:0]        rc;
  logic signed [43:0] term;

  logic               out_valid_q;
  logic [31:0]        lin_out_q, ang_out_q;

  logic               cordic_done, sqrt_done;
  logic signed [17:0] cos_w, sin_w;
  logic [22:0]        omega;
  logic [15:0]        abs_v;

  assign e3 = 17'(lh_q) - 17'(fh_q);

  lfc_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.cordic_start),
    .angle_i(cmd_i.ang_sel_e3 ? e3 : 17'(fh_q)),
    .done_o (cordic_done),
    .cos_o  (cos_w),
    .sin_o  (sin_w)
  );

  lfc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_start),
    .turn_i  (lw_q),
    .speed_i (lv_q),
    .weight_i(speed_w_q),
    .done_o  (sqrt_done),
    .root_o  (omega)
  );

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q  <= lfc_pkg::GOAL_X_RST;
      goal_y_q  <= lfc_pkg::GOAL_Y_RST;
      gain_q    <= lfc_pkg::GAIN_RST;
      speed_w_q <= lfc_pkg::SPEED_W_RST;
    end else if (cfg_valid_i) begin
      case (lfc_pkg::cfg_idx_e'(cfg_index_i))
        lfc_pkg::CFG_GOAL_X:  goal_x_q  <= cfg_data_i;
        lfc_pkg::CFG_GOAL_Y:  goal_y_q  <= cfg_data_i;
        lfc_pkg::CFG_GAIN:    gain_q    <= cfg_data_i[7:0];
        lfc_pkg::CFG_SPEED_W: speed_w_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // pose state update on an accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      lh_q <= '0;
      lv_q <= '0;
      lw_q <= '0;
      fx_q <= '0;
      fy_q <= '0;
      fh_q <= '0;
    end else if (cmd_i.load) begin
      if (robot_select_i == lfc_pkg::SEL_LEADER) begin
        lx_q <= pos_x_i;
        ly_q <= pos_y_i;
        lh_q <= heading_i;
        lv_q <= linear_speed_i;
        lw_q <= turn_rate_i;
      end else if (robot_select_i == lfc_pkg::SEL_FOLLOWER) begin
        fx_q <= pos_x_i;
        fy_q <= pos_y_i;
        fh_q <= heading_i;
      end
    end
  end

  // operand selection
  always_comb begin
    op_a    = '0;
    op_b    = '0;
    op_neg  = 1'b0;
    op_zero = 1'b0;
    case (cmd_i.prod)
      lfc_pkg::P_CDX: begin
        op_a = 38'(dx_q);
        op_b = 32'(c_q);
      end
      lfc_pkg::P_SDY: begin
        op_a = 38'(dy_q);
        op_b = 32'(s_q);
      end
      lfc_pkg::P_CDY: begin
        op_a = 38'(dy_q);
        op_b = 32'(c_q);
      end
      lfc_pkg::P_SDX: begin
        op_a   = 38'(dx_q);
        op_b   = 32'(s_q);
        op_neg = 1'b1;
      end
      lfc_pkg::P_VCE: begin
        op_a = 38'(ce3_q);
        op_b = 32'(lv_q);
      end
      lfc_pkg::P_KE1: begin
        op_a = e1_q;
        op_b = $signed({1'b0, k12_q});
      end
      lfc_pkg::P_KE2: begin
        // sign of leader speed folds in here
        op_a    = e2_q;
        op_b    = $signed({1'b0, k12_q});
        op_neg  = lv_q[15];
        op_zero = (lv_q == 16'sd0);
      end
      lfc_pkg::P_KE3: begin
        op_a = 38'(e3);
        op_b = $signed({1'b0, k3_q});
      end
      default: ;
    endcase
  end

  always_comb begin
    chunk = cmd_i.mul_hi ? mag_a_q[37:19] : mag_a_q[18:0];
    pp    = 50'(mag_b_q) * 50'(chunk);
  end

  // accumulate path
  always_comb begin
    sp     = neg_q ? -$signed(70'(prod_q)) : $signed(70'(prod_q));
    esum   = (cmd_i.prod[0] ? acc_e_q : 54'sd0) + 54'(sp);
    eround = (esum + 54'sd16384) >>> 15;
    case (cmd_i.prod)
      lfc_pkg::P_VCE: sh = 5'd11;
      lfc_pkg::P_KE3: sh = 5'd21;
      default:        sh = 5'd18;
    endcase
    shr  = prod_q >> (sh - 5'd1);
    rnd  = (shr >> 1) + 69'(shr[0]);
    rc   = (rnd > 69'(lfc_pkg::TERM_LIM)) ? lfc_pkg::TERM_LIM : rnd[40:0];
    if (zero_q) begin
      term = '0;
    end else if (neg_q) begin
      term = -$signed(44'(rc));
    end else begin
      term = $signed(44'(rc));
    end
  end

  assign abs_v = lv_q[15] ? 16'(-17'(lv_q)) : 16'(lv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.prep) begin
      dx_q <= 34'(lx_q) + 34'(goal_x_q) - 34'(fx_q);
      dy_q <= 34'(ly_q) + 34'(goal_y_q) - 34'(fy_q);
    end
    if (cmd_i.latch_cs) begin
      c_q <= cos_w;
      s_q <= sin_w;
    end
    if (cmd_i.latch_ce3) begin
      ce3_q <= cos_w;
    end
    if (cmd_i.gain_load) begin
      k12_q <= 31'(gain_q) * 31'(omega);
      k3_q  <= 31'(speed_w_q) * 31'(abs_v);
    end
    if (cmd_i.mul_sel) begin
      mag_a_q <= op_a[37] ? 38'(-op_a) : 38'(op_a);
      mag_b_q <= op_b[31] ? 31'(-op_b) : 31'(op_b);
      neg_q   <= op_a[37] ^ op_b[31] ^ op_neg;
      zero_q  <= op_zero;
    end
    if (cmd_i.mul_lo) begin
      prod_q <= 69'(pp);
    end else if (cmd_i.mul_hi) begin
      prod_q <= prod_q + (69'(pp) << 19);
    end
    if (cmd_i.mul_acc) begin
      case (cmd_i.prod)
        lfc_pkg::P_CDX, lfc_pkg::P_CDY: acc_e_q <= esum;
        lfc_pkg::P_SDY: e1_q <= 38'(eround);
        lfc_pkg::P_SDX: e2_q <= 38'(eround);
        lfc_pkg::P_VCE: lin_q <= term;
        lfc_pkg::P_KE1: lin_q <= lin_q + term;
        lfc_pkg::P_KE2: ang_q <= (44'(lw_q) <<< 4) + term;
        lfc_pkg::P_KE3: ang_q <= ang_q + term;
        default: ;
      endcase
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      lin_out_q <= lfc_pkg::sat32(lin_q);
      ang_out_q <= lfc_pkg::sat32(ang_q);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign linear_command_o   = lin_out_q;
  assign angular_command_o  = ang_out_q;
  assign stat_o.cordic_done = cordic_done;
  assign stat_o.sqrt_done   = sqrt_done;
  assign stat_o.out_busy    = out_valid_q && !out_ready_i;

endmodule

FILE: src/lfc_ctrl.sv
// ----------------------------------------------------------------------------
// lfc_ctrl
// sequencer: cordic runs, square root, multiply steps, output hand-off
// ----------------------------------------------------------------------------
module lfc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lfc_pkg::dp_stat_t stat_i,
  output lfc_pkg::dp_cmd_t  cmd_o
);

  lfc_pkg::ctrl_state_e state_q, state_d;
  lfc_pkg::prod_e       prod_q, prod_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfc_pkg::S_IDLE;
      prod_q  <= lfc_pkg::P_CDX;
    end else begin
      state_q <= state_d;
      prod_q  <= prod_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    prod_d     = prod_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.prod = prod_q;
    case (state_q)
      lfc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = lfc_pkg::S_PREP;
        end
      end
      lfc_pkg::S_PREP: begin
        cmd_o.prep         = 1'b1;
        cmd_o.cordic_start = 1'b1;
        cmd_o.sqrt_start   = 1'b1;
        state_d            = lfc_pkg::S_CS1;
      end
      lfc_pkg::S_CS1: begin
        if (stat_i.cordic_done) begin
          cmd_o.latch_cs     = 1'b1;
          cmd_o.cordic_start = 1'b1;
          cmd_o.ang_sel_e3   = 1'b1;
          state_d            = lfc_pkg::S_CS2;
        end
      end
      lfc_pkg::S_CS2: begin
        if (stat_i.cordic_done) begin
          cmd_o.latch_ce3 = 1'b1;
          state_d         = lfc_pkg::S_SQW;
        end
      end
      lfc_pkg::S_SQW: begin
        if (stat_i.sqrt_done) begin
          cmd_o.gain_load = 1'b1;
          prod_d          = lfc_pkg::P_CDX;
          state_d         = lfc_pkg::S_MSEL;
        end
      end
      lfc_pkg::S_MSEL: begin
        cmd_o.mul_sel = 1'b1;
        state_d       = lfc_pkg::S_MLO;
      end
      lfc_pkg::S_MLO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = lfc_pkg::S_MHI;
      end
      lfc_pkg::S_MHI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = lfc_pkg::S_MACC;
      end
      lfc_pkg::S_MACC: begin
        cmd_o.mul_acc = 1'b1;
        if (prod_q == lfc_pkg::P_KE3) begin
          state_d = lfc_pkg::S_DONE;
        end else begin
          prod_d  = lfc_pkg::prod_e'(prod_q + 3'd1);
          state_d = lfc_pkg::S_MSEL;
        end
      end
      lfc_pkg::S_DONE: begin
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = lfc_pkg::S_IDLE;
        end
      end
      default: state_d = lfc_pkg::S_IDLE;
    endcase
  end

endmodule

FILE: src/leader_follower_tracking_control.sv
// ----------------------------------------------------------------------------
// leader_follower_tracking_control
// unicycle trajectory tracking: one follower command per pose report
// ----------------------------------------------------------------------------
// Each accepted pose word (leader, follower or other robot) yields exactly one
// linear/angular command word for the follower; leader and follower words also
// update the stored pose. Words are handled one at a time. Between acceptance
// and the command being offered come two passes of the shared cordic
// (follower heading, then heading error) at one micro-rotation per cycle,
// then eight products on the shared 19 x 31 multiplier, each in four steps:
// operand select, low half, high half, accumulate. The 23-step square root
// for the natural frequency runs alongside the cordic passes. The input side
// takes a new word as soon as the sequencer is back in idle, even while the
// previous command still waits in the output register. Config writes are
// always taken and must only happen while no word is in flight.
// ----------------------------------------------------------------------------
module leader_follower_tracking_control #(
  parameter int CORDIC_STEPS = lfc_pkg::CORDIC_STEPS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  lfc_in_if.sink   in_i,
  lfc_out_if.source out_o,
  lfc_cfg_if.sink  cfg_i
);

  lfc_pkg::dp_cmd_t  cmd;
  lfc_pkg::dp_stat_t stat;
  logic              in_ready;
  logic              out_valid;
  logic [31:0]       lin_cmd, ang_cmd;

  // sequencer
  lfc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_ready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // state, arithmetic units and output word
  lfc_datapath #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .robot_select_i   (in_i.robot_select),
    .pos_x_i          (in_i.pos_x),
    .pos_y_i          (in_i.pos_y),
    .heading_i        (in_i.heading),
    .linear_speed_i   (in_i.linear_speed),
    .turn_rate_i      (in_i.turn_rate),
    .cfg_valid_i      (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .out_ready_i      (out_o.ready),
    .out_valid_o      (out_valid),
    .linear_command_o (lin_cmd),
    .angular_command_o(ang_cmd)
  );

  assign in_i.ready            = in_ready;
  assign cfg_i.ready           = 1'b1;  // config registers take a write every cycle
  assign out_o.valid           = out_valid;
  assign out_o.linear_command  = lin_cmd;
  assign out_o.angular_command = ang_cmd;

endmodule

FILE: src/lfc_checker.sv
// ----------------------------------------------------------------------------
// lfc_checker
// port-level checks of the tracking controller, bound to the top level
// ----------------------------------------------------------------------------
module lfc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // a held command stays offered until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("command word dropped before hand-off");

  // one word at a time: input closes right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input still open after accepting a word");

  // a command never appears the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("command offered too early");

endmodule

bind leader_follower_tracking_control lfc_checker u_lfc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready)
);
